// File: rtl/vdt_pkg.sv
`default_nettype none

package vdt_pkg;

	localparam int TABLE_DEPTH = 256;
	localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
	localparam int IDX_W       = 9;

	localparam logic signed [IDX_W-1:0] IDX_NONE = -9'sd1;

	localparam logic [31:0] ABS_MASK = 32'h7FFF_FFFF;
	localparam logic [31:0] EXP_MASK = 32'h7F80_0000;
	localparam logic [31:0] MAN_MASK = 32'h007F_FFFF;

	typedef struct packed {
		logic [31:0] x;
		logic [31:0] y;
		logic [31:0] z;
	} vtx_t;

	typedef struct packed {
		logic        start_new_mesh;
		logic        corner_absent;
		logic [31:0] coord_x;
		logic [31:0] coord_y;
		logic [31:0] coord_z;
	} in_item_t;

	typedef struct packed {
		logic signed [IDX_W-1:0] vertex_index;
		logic                    newly_added;
		logic                    table_overflow;
	} out_item_t;

	// probe token handed from cell to cell
	typedef struct packed {
		logic              live;
		logic              absent;
		logic              found;
		logic              added;
		logic [ADDR_W-1:0] idx;
	} tok_t;

	function automatic logic coord_is_nan(input logic [31:0] b);
		return ((b & EXP_MASK) == EXP_MASK) && ((b & MAN_MASK) != 32'd0);
	endfunction

	// float equality: +0 == -0, nan never equal
	function automatic logic coord_eq(input logic [31:0] a, input logic [31:0] b);
		logic both_zero;
		both_zero = ((a & ABS_MASK) == 32'd0) && ((b & ABS_MASK) == 32'd0);
		return !coord_is_nan(a) && !coord_is_nan(b) && (both_zero || (a == b));
	endfunction

	function automatic logic vtx_eq(input vtx_t a, input vtx_t b);
		return coord_eq(a.x, b.x) && coord_eq(a.y, b.y) && coord_eq(a.z, b.z);
	endfunction

	// table address to the 9-bit result field, masked or zero extended
	function automatic logic signed [IDX_W-1:0] to_index(input logic [ADDR_W-1:0] a);
		logic [ADDR_W+IDX_W-1:0] wide;
		wide = {{IDX_W{1'b0}}, a};
		return wide[IDX_W-1:0];
	endfunction

endpackage

`default_nettype wire

// File: rtl/vdt_cell.sv
`default_nettype none

module vdt_cell
	import vdt_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [ADDR_W-1:0] slot,
	input  wire logic [CNT_W-1:0]  count,
	input  wire vtx_t              query,
	input  wire tok_t              tok_in,
	output tok_t                   tok_out
);

	vtx_t entry_q;
	tok_t tok_q;
	tok_t tok_next;
	logic occupied;
	logic pending;
	logic hit;
	logic take;

	assign occupied = CNT_W'(slot) < count;
	assign pending  = tok_in.live && !tok_in.absent && !tok_in.found && !tok_in.added;
	assign hit      = pending && occupied && vtx_eq(entry_q, query);
	// first free slot takes the vertex
	assign take     = pending && !occupied;

	always_comb begin
		tok_next       = tok_in;
		tok_next.found = tok_in.found || hit;
		tok_next.added = tok_in.added || take;
		if (hit || take) begin
			tok_next.idx = slot;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			entry_q <= query;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_q <= '0;
		end else begin
			tok_q <= tok_next;
		end
	end

	assign tok_out = tok_q;

endmodule

`default_nettype wire

// File: rtl/vertex_dedup_table.sv
// the launch token walks the row of cells, one cell per clock; the result
//   goes to the output register, or waits in a hold register while it is full;
//   one corner is in flight at a time, in_ready is high only when idle
// reset: arst_n clears the stored count, the token chain and the output stage;
//   stored vertices keep whatever they held and are only read below the count
`default_nettype none

module vertex_dedup_table
	import vdt_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     in_valid,
	output logic          in_ready,
	input  wire in_item_t in_data,
	output logic          out_valid,
	input  wire logic     out_ready,
	output out_item_t     out_data
);

	typedef enum logic [1:0] {
		S_IDLE,
		S_RUN,
		S_HOLD
	} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  count_q;
	vtx_t              query_q;
	tok_t              launch_q;
	out_item_t         res_q;
	out_item_t         out_q;
	logic              out_valid_q;

	tok_t              chain[TABLE_DEPTH+1];
	out_item_t         res_now;
	logic              in_take;
	logic              slot_free;
	logic              out_load;

	assign in_ready  = (state_q == S_IDLE);
	assign in_take   = in_valid && in_ready;
	// output register frees up when empty or being drained this cycle
	assign slot_free = !out_valid_q || out_ready;
	// a finished lookup or a held result moves into the output register
	assign out_load  = slot_free
		&& (((state_q == S_RUN) && chain[TABLE_DEPTH].live) || (state_q == S_HOLD));

	// row of cells, each holds one table entry; the token enters at cell zero
	assign chain[0] = launch_q;

	for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
		vdt_cell u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.slot    (ADDR_W'(g)),
			.count   (count_q),
			.query   (query_q),
			.tok_in  (chain[g]),
			.tok_out (chain[g+1])
		);
	end

	// decode the token leaving the last cell
	always_comb begin
		res_now.vertex_index   = IDX_NONE;
		res_now.newly_added    = 1'b0;
		res_now.table_overflow = 1'b0;
		priority if (chain[TABLE_DEPTH].absent) begin
			res_now.vertex_index = IDX_NONE;
		end else if (chain[TABLE_DEPTH].found) begin
			res_now.vertex_index = to_index(chain[TABLE_DEPTH].idx);
		end else if (chain[TABLE_DEPTH].added) begin
			res_now.vertex_index = to_index(chain[TABLE_DEPTH].idx);
			res_now.newly_added  = 1'b1;
		end else begin
			// no match and no free slot
			res_now.table_overflow = 1'b1;
		end
	end

	// query coordinates stay put while the token walks
	always_ff @(posedge clk) begin
		if (in_take) begin
			query_q.x <= in_data.coord_x;
			query_q.y <= in_data.coord_y;
			query_q.z <= in_data.coord_z;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			launch_q    <= '0;
			res_q       <= '0;
			out_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// one-cycle launch pulse into the row
			launch_q.live <= in_take;
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_take) begin
						// clear before this corner is looked up
						if (in_data.start_new_mesh) begin
							count_q <= '0;
						end
						launch_q.absent <= in_data.corner_absent;
						launch_q.found  <= 1'b0;
						launch_q.added  <= 1'b0;
						launch_q.idx    <= '0;
						state_q         <= S_RUN;
					end
				end
				S_RUN: begin
					if (chain[TABLE_DEPTH].live) begin
						if (chain[TABLE_DEPTH].added && !chain[TABLE_DEPTH].found) begin
							count_q <= count_q + CNT_W'(1);
						end
						if (slot_free) begin
							out_q   <= res_now;
							state_q <= S_IDLE;
						end else begin
							res_q   <= res_now;
							state_q <= S_HOLD;
						end
					end
				end
				S_HOLD: begin
					// result waits for the output stage to drain
					if (slot_free) begin
						out_q   <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// token only leaves the row while a lookup is in flight
	a_tok_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		chain[TABLE_DEPTH].live |-> (state_q == S_RUN))
		else $error("token left the cell row outside a lookup");

	// a lookup never both matches and appends
	a_found_xor_added: assert property (@(posedge clk) disable iff (!arst_n)
		chain[TABLE_DEPTH].live |-> !(chain[TABLE_DEPTH].found && chain[TABLE_DEPTH].added))
		else $error("token both matched and appended");

	// stored count never passes the table depth
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(TABLE_DEPTH))
		else $error("stored count beyond table depth");

	// an append grows the table by exactly one
	a_append_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_RUN && chain[TABLE_DEPTH].live && chain[TABLE_DEPTH].added
			&& !chain[TABLE_DEPTH].found)
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("append did not advance the stored count");

	// overflow transactions carry the no-index code
	a_ovf_index: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_q.table_overflow) |-> (out_q.vertex_index == IDX_NONE
			&& !out_q.newly_added))
		else $error("overflow result with a real index");

endmodule

`default_nettype wire

// File: bench/dedup_checker.sv
`timescale 1ns / 100ps

module dedup_checker
	import vdt_pkg::*;
(
	input  logic      clk,
	input  logic      in_valid,
	input  logic      in_ready,
	input  in_item_t  in_data,
	input  logic      out_valid,
	input  logic      out_ready,
	input  out_item_t out_data,
	output int        fail_count,
	output int        pending,
	output int        appended_seen,
	output int        overflow_seen
);

	vtx_t      welded [TABLE_DEPTH];
	int        welded_count;
	out_item_t awaited_results [$];

	initial begin
		fail_count    = 0;
		pending       = 0;
		appended_seen = 0;
		overflow_seen = 0;
		welded_count  = 0;
	end

	function automatic bit is_nan(input logic [31:0] b);
		return b[30:23] == 8'hFF && b[22:0] != '0;
	endfunction

	// float compare: signed zeros equal, nan equal to nothing
	function automatic bit same_float(input logic [31:0] a, input logic [31:0] b);
		if (is_nan(a) || is_nan(b))
			return 1'b0;
		if (a[30:0] == '0 && b[30:0] == '0)
			return 1'b1;
		return a == b;
	endfunction

	// look the corner up, append it when new, and give the result it must produce
	function automatic out_item_t weld_corner(input in_item_t c);
		out_item_t r;
		int        hit;
		r = out_item_t'{vertex_index: IDX_NONE, newly_added: 1'b0, table_overflow: 1'b0};
		if (c.start_new_mesh)
			welded_count = 0;
		if (c.corner_absent)
			return r;
		hit = -1;
		for (int i = 0; i < welded_count && hit < 0; i++) begin
			if (same_float(welded[i].x, c.coord_x) && same_float(welded[i].y, c.coord_y) &&
			    same_float(welded[i].z, c.coord_z))
				hit = i;
		end
		if (hit >= 0) begin
			r.vertex_index = hit[IDX_W-1:0];
		end else if (welded_count < TABLE_DEPTH) begin
			welded[welded_count] = vtx_t'{c.coord_x, c.coord_y, c.coord_z};
			r.vertex_index = welded_count[IDX_W-1:0];
			r.newly_added = 1'b1;
			welded_count++;
		end else begin
			r.table_overflow = 1'b1;
		end
		return r;
	endfunction

	always @(posedge clk) begin
		out_item_t want;
		if (in_valid && in_ready) begin
			want = weld_corner(in_data);
			appended_seen += want.newly_added;
			overflow_seen += want.table_overflow;
			awaited_results.push_back(want);
		end
		if (out_valid && out_ready) begin
			if (awaited_results.size() == 0) begin
				fail_count++;
				$display("%0t: result with none expected: index %0d added %0b overflow %0b",
					$time, out_data.vertex_index, out_data.newly_added,
					out_data.table_overflow);
			end else begin
				want = awaited_results.pop_front();
				if (out_data.vertex_index !== want.vertex_index ||
				    out_data.newly_added !== want.newly_added ||
				    out_data.table_overflow !== want.table_overflow) begin
					fail_count++;
					$display({"%0t: mismatch, expected index %0d added %0b overflow %0b,",
						" got index %0d added %0b overflow %0b"},
						$time, want.vertex_index, want.newly_added, want.table_overflow,
						out_data.vertex_index, out_data.newly_added, out_data.table_overflow);
				end
			end
		end
		pending = awaited_results.size();
	end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps

module testbench;
	import vdt_pkg::*;

	localparam int CORNER_TARGET = 800;
	localparam int CALM_TAIL     = 100;  // closing corners sent with no idling on either side
	localparam int BIG_MESH      = 400;  // enough fresh vertices to fill the table and spill over

	logic      clk = 1'b0;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;

	int   fail_count;
	int   pending;
	int   appended_seen;
	int   overflow_seen;
	int   corners_sent = 0;
	int   meshes_begun = 0;
	bit   idling_on = 1'b1;
	vtx_t mesh_pool [$];  // vertices already sent in the current mesh, for reuse

	vertex_dedup_table dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data (out_data)
	);

	dedup_checker chk (
		.clk          (clk),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.in_data      (in_data),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.out_data     (out_data),
		.fail_count   (fail_count),
		.pending      (pending),
		.appended_seen(appended_seen),
		.overflow_seen(overflow_seen)
	);

	always #2 clk = ~clk;

	// hard stop in case the table hangs; a correct run takes under a millisecond
	initial begin
		#4ms;
		$display("timeout: results still outstanding");
		$display("simulation failed");
		$finish;
	end

	function automatic in_item_t corner(input bit start, input bit absent, input vtx_t v);
		return in_item_t'{start_new_mesh: start, corner_absent: absent,
			coord_x: v.x, coord_y: v.y, coord_z: v.z};
	endfunction

	// mostly arbitrary bit patterns, with zeros, infinities and nans mixed in
	function automatic logic [31:0] pick_coord();
		if ($urandom_range(99) >= 20)
			return $urandom();
		case ($urandom_range(9))
			0:       return 32'h0000_0000;  // +0
			1:       return 32'h8000_0000;  // -0
			2:       return 32'h3F80_0000;  // 1.0
			3:       return 32'hBF80_0000;  // -1.0
			4:       return 32'h7F80_0000;  // +inf
			5:       return 32'hFF80_0000;  // -inf
			6:       return 32'h7FC0_0000;  // quiet nan
			7:       return 32'h7F80_0001;  // signaling nan
			8:       return 32'hFFFF_FFFF;  // all ones, a nan
			default: return 32'h0000_0001;  // smallest denormal
		endcase
	endfunction

	function automatic vtx_t fresh_vertex();
		return vtx_t'{pick_coord(), pick_coord(), pick_coord()};
	endfunction

	// a zero may come back with the other sign and must still weld
	function automatic logic [31:0] flip_zero(input logic [31:0] b);
		if (b[30:0] == '0 && $urandom_range(1))
			b[31] = ~b[31];
		return b;
	endfunction

	// one input transaction; valid stays up across back-to-back corners
	task automatic send_corner(input in_item_t c);
		int gap;
		gap = (idling_on && $urandom_range(99) < 20) ? $urandom_range(7, 1) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= c;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		corners_sent++;
	endtask

	// one mesh: a clear on the first corner, then absent corners and fresh, reused and near-miss vertices
	task automatic run_mesh(input int n, input int fresh_pct, input bit stray_clears);
		vtx_t v;
		int   roll;
		int   b;
		bit   start;
		meshes_begun++;
		mesh_pool.delete();
		for (int k = 0; k < n && corners_sent < CORNER_TARGET; k++) begin
			if (corners_sent >= CORNER_TARGET - CALM_TAIL)
				idling_on = 1'b0;
			roll  = $urandom_range(99);
			start = (k == 0);
			// now and then a clear lands in the middle of a mesh
			if (stray_clears && k > 0 && $urandom_range(199) == 0) begin
				start = 1'b1;
				mesh_pool.delete();
			end
			if (roll < 6) begin
				// absent corner carrying garbage coordinates
				send_corner(corner(start, 1'b1, fresh_vertex()));
			end else if (mesh_pool.size() == 0 || roll < 6 + fresh_pct) begin
				v = fresh_vertex();
				mesh_pool.push_back(v);
				send_corner(corner(start, 1'b0, v));
			end else begin
				v = mesh_pool[$urandom_range(mesh_pool.size() - 1)];
				if (roll < 14 + fresh_pct) begin
					// one bit off an earlier vertex
					b = $urandom_range(31);
					case ($urandom_range(2))
						0:       v.x[b] = ~v.x[b];
						1:       v.y[b] = ~v.y[b];
						default: v.z[b] = ~v.z[b];
					endcase
					mesh_pool.push_back(v);
				end else begin
					v = vtx_t'{flip_zero(v.x), flip_zero(v.y), flip_zero(v.z)};
				end
				send_corner(corner(start, 1'b0, v));
			end
		end
	endtask

	// result side: random stall bursts while idling is on, otherwise always ready
	initial begin
		int hold;
		hold      = 0;
		out_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (idling_on && $urandom_range(99) < 25) begin
				hold = $urandom_range(7, 1) - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		vtx_t one_two_three;
		vtx_t big_pair;
		arst_n   = 1'b0;
		in_valid = 1'b0;
		in_data  = '0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		one_two_three = vtx_t'{32'h3F80_0000, 32'h4000_0000, 32'h4040_0000};
		big_pair      = vtx_t'{32'h7F7F_FFFF, 32'hFF7F_FFFF, 32'h8000_0000};

		// directed corners: signed zeros, nans, absent corners, clears, extreme patterns
		send_corner(corner(1'b1, 1'b0, vtx_t'{32'h0, 32'h0, 32'h0}));
		send_corner(corner(1'b0, 1'b0, vtx_t'{32'h8000_0000, 32'h0, 32'h8000_0000}));
		send_corner(corner(1'b0, 1'b0, one_two_three));
		send_corner(corner(1'b0, 1'b0, one_two_three));
		send_corner(corner(1'b0, 1'b0, vtx_t'{32'h7FC0_0000, 32'h0, 32'h0}));
		send_corner(corner(1'b0, 1'b0, vtx_t'{32'h7FC0_0000, 32'h0, 32'h0}));
		send_corner(corner(1'b0, 1'b1, vtx_t'{'1, '1, '1}));
		send_corner(corner(1'b1, 1'b1, vtx_t'{32'h0, 32'h0, 32'h0}));
		send_corner(corner(1'b0, 1'b0, vtx_t'{'1, '1, '1}));
		send_corner(corner(1'b0, 1'b0, vtx_t'{32'h0, 32'h0, 32'h0}));
		send_corner(corner(1'b0, 1'b0, vtx_t'{32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF}));
		send_corner(corner(1'b0, 1'b0, vtx_t'{32'h7F80_0000, 32'hFF80_0000, 32'h7F7F_FFFF}));
		send_corner(corner(1'b0, 1'b0, vtx_t'{32'h0000_0001, 32'h8000_0001, 32'h0080_0000}));
		send_corner(corner(1'b0, 1'b0, vtx_t'{32'h8000_0001, 32'h0000_0001, 32'h0080_0000}));
		send_corner(corner(1'b1, 1'b0, one_two_three));
		send_corner(corner(1'b0, 1'b0, vtx_t'{one_two_three.x, one_two_three.y, 32'h7FC0_0000}));
		send_corner(corner(1'b0, 1'b0, vtx_t'{one_two_three.x, 32'hFF80_0001, one_two_three.z}));
		send_corner(corner(1'b0, 1'b0, one_two_three));
		send_corner(corner(1'b0, 1'b0, big_pair));
		send_corner(corner(1'b0, 1'b0, vtx_t'{big_pair.x, big_pair.y, 32'h0}));
		send_corner(corner(1'b0, 1'b1, one_two_three));
		send_corner(corner(1'b0, 1'b0, vtx_t'{32'h8000_0000, 32'h8000_0000, 32'h8000_0000}));

		// random meshes: one large enough to fill the table, the rest small and reuse-heavy
		run_mesh($urandom_range(10, 30), 35, 1'b1);
		run_mesh(BIG_MESH, 70, 1'b0);
		while (corners_sent < CORNER_TARGET)
			run_mesh($urandom_range(5, 40), 35, 1'b1);
		in_valid <= 1'b0;

		// drain, then give the table a full probe pass to show any stray result
		while (pending != 0)
			@(negedge clk);
		repeat (TABLE_DEPTH + 8) @(negedge clk);

		$display("sent %0d corners over %0d random meshes plus the directed set",
			corners_sent, meshes_begun);
		$display("expected %0d vertices appended and %0d table overflows",
			appended_seen, overflow_seen);
		if (fail_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

// File: sim.f
rtl/vdt_pkg.sv
rtl/vdt_cell.sv
rtl/vertex_dedup_table.sv
bench/dedup_checker.sv
bench/testbench.sv
